/* rtl/tsc_pkg.sv */
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants for the Taylor-series sine/cosine block:
// microcode control word, status bundle, series and reduction constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

    // internal fixed-point fraction bits (Q58 in 64 bits)
    localparam int IQ = 58;

    localparam logic [3:0]  NUM_TERMS_RST  = 4'd10;
    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
    localparam logic [63:0] TWO_PI_Q61     = 64'hC90F_DAA2_2168_C235;

    // 2^(IQ+1); coefficients are round-half-up(2^IQ / k!)
    localparam logic [63:0] INV_FACT_NUM = 64'd1 << (IQ + 1);

    localparam logic [63:0] INV_FACT [32] = '{
        (INV_FACT_NUM / 64'd1                  + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd1                  + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd2                  + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd6                  + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd24                 + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd120                + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd720                + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd5040               + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd40320              + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd362880             + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd3628800            + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd39916800           + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd479001600          + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd6227020800         + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd87178291200        + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd1307674368000      + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd20922789888000     + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd355687428096000    + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd6402373705728000   + 64'd1) >> 1,
        (INV_FACT_NUM / 64'd121645100408832000 + 64'd1) >> 1,
        64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0,
        64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0
    };

    typedef logic [4:0] step_t;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_RED_LOAD,   // |angle| x 1/(2pi)
        UOP_FRAC,       // take turn fraction, load x 2pi
        UOP_XFIN,       // x done, load x*x
        UOP_INIT,       // x2 done, acc = top coefficient
        UOP_TERM_LOAD,  // load acc*x2, step term index down
        UOP_HORNER,     // acc = c(i) + acc*x2
        UOP_SIN_LOAD,   // load x*acc
        UOP_SIN_FIN,    // acc = x*acc
        UOP_OUT         // round and emit
    } uop_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_LL,
        MUL_LH,
        MUL_HL,
        MUL_HH
    } mul_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_S0,
        ACC_S32,
        ACC_S64
    } acc_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_IF_ZERO,
        JMP_IF_COS,
        JMP_END
    } jmp_t;

    typedef struct packed {
        uop_t  uop;
        mul_t  mul;
        acc_t  acc;
        jmp_t  jmp;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic cosine;
        logic i_zero;
    } stat_t;

    localparam ctrl_t CTRL_NOP = '{
        uop: UOP_NOP, mul: MUL_NONE, acc: ACC_NONE, jmp: JMP_NEXT, target: '0
    };

endpackage

`default_nettype wire

/* rtl/tsc_seq.sv */
// ----------------------------------------------------------------------------
// tsc_seq
// Microcode sequencer: step counter, control ROM and jump logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_seq
    import tsc_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   start,
    input  wire   hold,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  busy
);

    localparam step_t STEP_LOOP = 5'd17;
    localparam step_t STEP_TAIL = 5'd24;
    localparam step_t STEP_OUT  = 5'd31;

    logic  busy_reg, busy_next;
    step_t step_reg, step_next;
    ctrl_t rom_word;

    function automatic ctrl_t word(uop_t u, mul_t m, acc_t a, jmp_t j, step_t t);
        ctrl_t w;
        w.uop    = u;
        w.mul    = m;
        w.acc    = a;
        w.jmp    = j;
        w.target = t;
        return w;
    endfunction

    // 64x64 products take four 32x32 passes; ACC adds the previous pass
    always_comb
    begin
        case (step_reg)
            5'd0:  rom_word = word(UOP_RED_LOAD,  MUL_NONE, ACC_NONE, JMP_NEXT, '0);
            5'd1:  rom_word = word(UOP_NOP,       MUL_LL,   ACC_NONE, JMP_NEXT, '0);
            5'd2:  rom_word = word(UOP_NOP,       MUL_LH,   ACC_S0,   JMP_NEXT, '0);
            5'd3:  rom_word = word(UOP_NOP,       MUL_NONE, ACC_S32,  JMP_NEXT, '0);
            5'd4:  rom_word = word(UOP_FRAC,      MUL_NONE, ACC_NONE, JMP_NEXT, '0);
            5'd5:  rom_word = word(UOP_NOP,       MUL_LL,   ACC_NONE, JMP_NEXT, '0);
            5'd6:  rom_word = word(UOP_NOP,       MUL_LH,   ACC_S0,   JMP_NEXT, '0);
            5'd7:  rom_word = word(UOP_NOP,       MUL_HL,   ACC_S32,  JMP_NEXT, '0);
            5'd8:  rom_word = word(UOP_NOP,       MUL_HH,   ACC_S32,  JMP_NEXT, '0);
            5'd9:  rom_word = word(UOP_NOP,       MUL_NONE, ACC_S64,  JMP_NEXT, '0);
            5'd10: rom_word = word(UOP_XFIN,      MUL_NONE, ACC_NONE, JMP_NEXT, '0);
            5'd11: rom_word = word(UOP_NOP,       MUL_LL,   ACC_NONE, JMP_NEXT, '0);
            5'd12: rom_word = word(UOP_NOP,       MUL_LH,   ACC_S0,   JMP_NEXT, '0);
            5'd13: rom_word = word(UOP_NOP,       MUL_HL,   ACC_S32,  JMP_NEXT, '0);
            5'd14: rom_word = word(UOP_NOP,       MUL_HH,   ACC_S32,  JMP_NEXT, '0);
            5'd15: rom_word = word(UOP_NOP,       MUL_NONE, ACC_S64,  JMP_NEXT, '0);
            5'd16: rom_word = word(UOP_INIT,      MUL_NONE, ACC_NONE, JMP_NEXT, '0);
            5'd17: rom_word = word(UOP_TERM_LOAD, MUL_NONE, ACC_NONE, JMP_IF_ZERO,
                                   STEP_TAIL);
            5'd18: rom_word = word(UOP_NOP,       MUL_LL,   ACC_NONE, JMP_NEXT, '0);
            5'd19: rom_word = word(UOP_NOP,       MUL_LH,   ACC_S0,   JMP_NEXT, '0);
            5'd20: rom_word = word(UOP_NOP,       MUL_HL,   ACC_S32,  JMP_NEXT, '0);
            5'd21: rom_word = word(UOP_NOP,       MUL_HH,   ACC_S32,  JMP_NEXT, '0);
            5'd22: rom_word = word(UOP_NOP,       MUL_NONE, ACC_S64,  JMP_NEXT, '0);
            5'd23: rom_word = word(UOP_HORNER,    MUL_NONE, ACC_NONE, JMP_ALWAYS,
                                   STEP_LOOP);
            5'd24: rom_word = word(UOP_SIN_LOAD,  MUL_NONE, ACC_NONE, JMP_IF_COS,
                                   STEP_OUT);
            5'd25: rom_word = word(UOP_NOP,       MUL_LL,   ACC_NONE, JMP_NEXT, '0);
            5'd26: rom_word = word(UOP_NOP,       MUL_LH,   ACC_S0,   JMP_NEXT, '0);
            5'd27: rom_word = word(UOP_NOP,       MUL_HL,   ACC_S32,  JMP_NEXT, '0);
            5'd28: rom_word = word(UOP_NOP,       MUL_HH,   ACC_S32,  JMP_NEXT, '0);
            5'd29: rom_word = word(UOP_NOP,       MUL_NONE, ACC_S64,  JMP_NEXT, '0);
            5'd30: rom_word = word(UOP_SIN_FIN,   MUL_NONE, ACC_NONE, JMP_NEXT, '0);
            5'd31: rom_word = word(UOP_OUT,       MUL_NONE, ACC_NONE, JMP_END,  '0);
            default: rom_word = CTRL_NOP;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end
        else
        begin
            case (rom_word.jmp)
                JMP_NEXT:    step_next = step_reg + 5'd1;
                JMP_ALWAYS:  step_next = rom_word.target;
                JMP_IF_ZERO: step_next = stat.i_zero ? rom_word.target : step_reg + 5'd1;
                JMP_IF_COS:  step_next = stat.cosine ? rom_word.target : step_reg + 5'd1;
                JMP_END:
                begin
                    // wait here while the output register still holds a beat
                    if (!hold)
                    begin
                        busy_next = 1'b0;
                        step_next = '0;
                    end
                end
                default:     step_next = step_reg + 5'd1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign ctrl = busy_reg ? rom_word : CTRL_NOP;
    assign busy = busy_reg;

endmodule

`default_nettype wire

/* rtl/tsc_dp.sv */
// ----------------------------------------------------------------------------
// tsc_dp
// Datapath: 32x32 multiplier, 128-bit partial-product accumulator, angle
// reduction, Horner registers and output rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_dp
    import tsc_pkg::*;
#(
    parameter int MAX_TERMS = 10,
    parameter int FRAC_BITS = 28
)
(
    input  wire         clk,
    input  wire         start,
    input  wire         op_in,
    input  wire  [31:0] angle_in,
    input  wire  [3:0]  num_terms,
    input  ctrl_t       ctrl,
    output stat_t       stat,
    output logic [31:0] value
);

    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int SH = IQ - FRAC_BITS;

    logic          op_reg,    op_next;
    logic [31:0]   angle_reg, angle_next;
    logic [63:0]   a_reg,     a_next;
    logic [63:0]   b_reg,     b_next;
    logic          neg_reg,   neg_next;
    logic [63:0]   mul_reg,   mul_next;
    logic [127:0]  prod_reg,  prod_next;
    logic [63:0]   x_reg,     x_next;
    logic [63:0]   x2_reg,    x2_next;
    logic [63:0]   acc_reg,   acc_next;
    logic [IW-1:0] i_reg,     i_next;

    logic [31:0]   mul_a, mul_b;
    logic [31:0]   ang_mag;
    logic [127:0]  prod_sgn;
    logic [63:0]   frac, frac_mag;
    logic [63:0]   xr_mag;
    logic [71:0]   q_rnd;
    logic [70:0]   q_r;
    logic [62:0]   q_mag;
    logic [63:0]   q_res;
    logic [4:0]    n_w, n_m1_w;
    logic [IW-1:0] n_m1, coef_i;
    logic [4:0]    coef_idx;
    logic [63:0]   coef;
    logic [63:0]   acc_mag, x_mag;
    logic [64:0]   out_rnd, out_r;

    // term count clamped to 1..MAX_TERMS
    always_comb
    begin
        if (num_terms == 4'd0)
            n_w = 5'd1;
        else if ({1'b0, num_terms} > 5'(MAX_TERMS))
            n_w = 5'(MAX_TERMS);
        else
            n_w = {1'b0, num_terms};
        n_m1_w = n_w - 5'd1;
    end
    assign n_m1 = n_m1_w[IW-1:0];

    // coefficient k = 2i (cosine) or 2i+1 (sine), negative for odd i
    assign coef_i   = (ctrl.uop == UOP_INIT) ? n_m1 : i_reg;
    assign coef_idx = 5'({coef_i, ~op_reg});
    assign coef     = coef_i[0] ? (64'd0 - INV_FACT[coef_idx]) : INV_FACT[coef_idx];

    assign ang_mag  = angle_reg[31] ? (32'd0 - angle_reg) : angle_reg;
    assign prod_sgn = neg_reg ? (128'd0 - prod_reg) : prod_reg;
    assign frac     = prod_sgn[FRAC_BITS +: 64];
    assign frac_mag = frac[63] ? (64'd0 - frac) : frac;
    assign xr_mag   = {3'd0, prod_reg[127:67]};

    // Q58 product: round half up at bit 58, saturate magnitude, apply sign
    assign q_rnd = {1'b0, prod_reg[127:57]} + 72'd1;
    assign q_r   = q_rnd[71:1];
    assign q_mag = (|q_r[70:63]) ? {63{1'b1}} : q_r[62:0];
    assign q_res = neg_reg ? (64'd0 - {1'b0, q_mag}) : {1'b0, q_mag};

    assign acc_mag = acc_reg[63] ? (64'd0 - acc_reg) : acc_reg;
    assign x_mag   = x_reg[63]   ? (64'd0 - x_reg)   : x_reg;

    always_comb
    begin
        case (ctrl.mul)
            MUL_LL:
            begin
                mul_a = a_reg[31:0];
                mul_b = b_reg[31:0];
            end
            MUL_LH:
            begin
                mul_a = a_reg[31:0];
                mul_b = b_reg[63:32];
            end
            MUL_HL:
            begin
                mul_a = a_reg[63:32];
                mul_b = b_reg[31:0];
            end
            MUL_HH:
            begin
                mul_a = a_reg[63:32];
                mul_b = b_reg[63:32];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        op_next    = op_reg;
        angle_next = angle_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        neg_next   = neg_reg;
        mul_next   = mul_reg;
        prod_next  = prod_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        acc_next   = acc_reg;
        i_next     = i_reg;

        if (start)
        begin
            op_next    = op_in;
            angle_next = angle_in;
        end

        if (ctrl.mul != MUL_NONE)
            mul_next = {32'd0, mul_a} * {32'd0, mul_b};

        case (ctrl.acc)
            ACC_S0:  prod_next = prod_reg + {64'd0, mul_reg};
            ACC_S32: prod_next = prod_reg + {32'd0, mul_reg, 32'd0};
            ACC_S64: prod_next = prod_reg + {mul_reg, 64'd0};
            default: prod_next = prod_reg;
        endcase

        case (ctrl.uop)
            UOP_RED_LOAD:
            begin
                a_next    = {32'd0, ang_mag};
                b_next    = INV_TWO_PI_Q64;
                neg_next  = angle_reg[31];
                prod_next = '0;
            end
            UOP_FRAC:
            begin
                // fraction of a turn in [-0.5, 0.5), magnitude times 2pi
                a_next    = frac_mag;
                b_next    = TWO_PI_Q61;
                neg_next  = frac[63];
                prod_next = '0;
            end
            UOP_XFIN:
            begin
                x_next    = neg_reg ? (64'd0 - xr_mag) : xr_mag;
                a_next    = xr_mag;
                b_next    = xr_mag;
                neg_next  = 1'b0;
                prod_next = '0;
            end
            UOP_INIT:
            begin
                x2_next  = q_res;
                acc_next = coef;
                i_next   = n_m1;
            end
            UOP_TERM_LOAD:
            begin
                a_next    = acc_mag;
                b_next    = x2_reg;
                neg_next  = acc_reg[63];
                i_next    = i_reg - IW'(1);
                prod_next = '0;
            end
            UOP_HORNER:
            begin
                acc_next = coef + q_res;
            end
            UOP_SIN_LOAD:
            begin
                a_next    = x_mag;
                b_next    = acc_mag;
                neg_next  = x_reg[63] ^ acc_reg[63];
                prod_next = '0;
            end
            UOP_SIN_FIN:
            begin
                acc_next = q_res;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        angle_reg <= angle_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        neg_reg   <= neg_next;
        mul_reg   <= mul_next;
        prod_reg  <= prod_next;
        x_reg     <= x_next;
        x2_reg    <= x2_next;
        acc_reg   <= acc_next;
        i_reg     <= i_next;
    end

    // Q58 to output format, round half up on magnitude, saturate to 32 bits
    assign out_rnd = {1'b0, acc_mag} + (65'd1 << (SH - 1));
    assign out_r   = out_rnd >> SH;

    always_comb
    begin
        if (acc_reg[63])
        begin
            if (out_r > 65'h0_8000_0000)
                value = 32'h8000_0000;
            else
                value = 32'd0 - out_r[31:0];
        end
        else
        begin
            if (out_r > 65'h0_7FFF_FFFF)
                value = 32'h7FFF_FFFF;
            else
                value = out_r[31:0];
        end
    end

    assign stat.cosine = op_reg;
    assign stat.i_zero = (i_reg == '0);

endmodule

`default_nettype wire

/* rtl/taylor_sine_cosine.sv */
// ----------------------------------------------------------------------------
// taylor_sine_cosine
// Fixed-point sine/cosine by Taylor series with modulo-2pi angle reduction.
// ----------------------------------------------------------------------------
// The time from accept to m_tvalid grows with n = num_terms clamped to
// 1..MAX_TERMS; sine adds a final x*acc product that cosine skips.
// One item at a time; next beat taken in the cycle after the result is loaded.
// The single 32x32 multiplier takes four passes per 64-bit product, and each
// Horner term takes seven microcode steps.
// Reset: idle, output empty, num_terms = 10.
`default_nettype none

module taylor_sine_cosine
    import tsc_pkg::*;
#(
    parameter int MAX_TERMS = 10,
    parameter int FRAC_BITS = 28
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] angle
    input  wire         s_tuser,   // [0] op
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [3:0]  cfg_data
);

    logic [3:0]  num_terms_reg, num_terms_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] value_reg,     value_next;

    logic        start, hold, busy, out_load;
    ctrl_t       ctrl;
    stat_t       stat;
    logic [31:0] dp_value;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy;
    assign start     = s_tvalid && s_tready;
    assign hold      = out_valid_reg && !m_tready;
    assign out_load  = (ctrl.uop == UOP_OUT) && !hold;

    tsc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .hold  (hold),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    tsc_dp #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .start     (start),
        .op_in     (s_tuser),
        .angle_in  (s_tdata),
        .num_terms (num_terms_reg),
        .ctrl      (ctrl),
        .stat      (stat),
        .value     (dp_value)
    );

    always_comb
    begin
        num_terms_next = num_terms_reg;
        if (cfg_valid && cfg_ready)
            num_terms_next = cfg_data;

        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            value_next     = dp_value;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_terms_reg <= NUM_TERMS_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            num_terms_reg <= num_terms_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = value_reg;

    // an accepted beat starts the program at the reduction step
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (busy && ctrl.uop == UOP_RED_LOAD))
        else $error("accepted beat did not start the microprogram");

    // loading the result ends the item and presents it
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_tvalid && !busy))
        else $error("result load did not end the item");

    // the program only ends on the output step
    a_end_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && ctrl.jmp == JMP_END) |-> (ctrl.uop == UOP_OUT))
        else $error("microprogram ends outside the output step");

endmodule

`default_nettype wire

/* dv/taylor_sine_cosine_tb.sv */
// ----------------------------------------------------------------------------
// taylor_sine_cosine_tb
// Self-checking bench for the Taylor-series sine/cosine block. A bit-exact
// fixed-point predictor (angle reduction, Horner series in x*x, Q28 output
// rounding) scores every result beat in order. Directed angles come first,
// then random phases that each write a term count first. The sender works
// in bursts, the receiver stalls in patterns, and one long receiver hold
// backs the block up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

typedef enum bit {
    OP_SINE   = 1'b0,
    OP_COSINE = 1'b1
} trig_op_t;

typedef struct {
    trig_op_t    op;
    logic [31:0] angle;
    logic [31:0] value;
} trig_expect_t;

class sincos_scoreboard;
    localparam int          IQ        = 58;
    localparam int          FRAC      = 28;
    localparam int          TERMS_MAX = 10;
    localparam logic [63:0] INV_2PI   = 64'h28BE_60DB_9391_054A;   // Q0.64, truncated
    localparam logic [63:0] TWO_PI    = 64'hC90F_DAA2_2168_C235;   // Q3.61, rounded
    localparam logic [63:0] POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

    logic [3:0]   num_terms;
    trig_expect_t expected_values[$];
    int           errors;
    int           results_seen;

    function new();
        num_terms    = 4'd10;
        errors       = 0;
        results_seen = 0;
    endfunction

    function logic [63:0] abs64(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // clamp magnitude to 2^63-1, then negate if needed
    function logic [63:0] with_sign(logic [63:0] m, bit neg);
        if (m > POS_MAX)
            m = POS_MAX;
        return neg ? (64'd0 - m) : m;
    endfunction

    // Q58 multiply: round magnitude half up, saturate
    function logic [63:0] q58_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        logic [63:0]  m;
        p = {64'd0, abs64(a)} * {64'd0, abs64(b)} + (128'd1 << (IQ - 1));
        if (p[127:IQ + 63] != 0)
            m = POS_MAX;
        else
            m = p[IQ + 63:IQ];
        return with_sign(m, a[63] ^ b[63]);
    endfunction

    function logic [63:0] inv_fact(int k);
        logic [63:0] v;
        int          j;
        v = 64'd1 << (IQ + 1);
        for (j = 2; j <= k; j++)
            v = v / 64'(j);
        return (v + 64'd1) >> 1;
    endfunction

    // angle mod 2pi into [-pi, pi), Q58
    function logic [63:0] reduce_turn(logic [31:0] a);
        logic [32:0]  m;
        logic [127:0] p;
        logic [127:0] q;
        logic [63:0]  frac;
        logic [63:0]  fm;
        m = a[31] ? (33'h1_0000_0000 - {1'b0, a}) : {1'b0, a};
        p = {95'd0, m} * {64'd0, INV_2PI};
        if (a[31])
            p = 128'd0 - p;
        frac = p[FRAC + 63:FRAC];
        fm   = frac[63] ? (64'd0 - frac) : frac;
        q    = {64'd0, fm} * {64'd0, TWO_PI};
        return with_sign({3'd0, q[127:67]}, frac[63]);
    endfunction

    function logic [31:0] sincos_q28(trig_op_t op, logic [31:0] angle);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] c;
        logic [63:0] y;
        logic [64:0] r;
        int          n;
        int          i;
        x  = reduce_turn(angle);
        x2 = q58_mul(x, x);
        n  = int'(num_terms);
        if (n < 1)
            n = 1;
        if (n > TERMS_MAX)
            n = TERMS_MAX;
        acc = 64'd0;
        for (i = n - 1; i >= 0; i--)
        begin
            c = inv_fact(2 * i + ((op == OP_COSINE) ? 0 : 1));
            if (i % 2)
                c = 64'd0 - c;
            acc = (i == n - 1) ? c : (c + q58_mul(acc, x2));
        end
        y = (op == OP_COSINE) ? acc : q58_mul(x, acc);
        r = ({1'b0, abs64(y)} + (65'd1 << (IQ - FRAC - 1))) >> (IQ - FRAC);
        if (y[63])
        begin
            if (r > 65'h8000_0000)
                r = 65'h8000_0000;
            return 32'd0 - r[31:0];
        end
        if (r > 65'h7FFF_FFFF)
            r = 65'h7FFF_FFFF;
        return r[31:0];
    endfunction

    function void set_terms(logic [3:0] v);
        num_terms = v;
    endfunction

    function void note_input(trig_op_t op, logic [31:0] angle);
        trig_expect_t e;
        e.op    = op;
        e.angle = angle;
        e.value = sincos_q28(op, angle);
        expected_values.push_back(e);
    endfunction

    function void check_result(logic [31:0] got);
        trig_expect_t e;
        results_seen++;
        if (expected_values.size() == 0)
        begin
            $error("value: unexpected result beat, actual %h", got);
            errors++;
            return;
        end
        e = expected_values.pop_front();
        if (got !== e.value)
        begin
            $error("value: expected %h actual %h (op %s angle %h terms %0d)",
                   e.value, got, e.op.name(), e.angle, num_terms);
            errors++;
        end
    endfunction
endclass

module taylor_sine_cosine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PI_Q        = 843314857;    // pi in Q4.28
    localparam int HALF_PI_Q   = 421657428;
    localparam int TWO_PI_Q    = 1686629713;
    localparam int PHASE_ITEMS = 195;
    localparam int NUM_PHASES  = 10;
    localparam int SETTLE      = 4;
    localparam int TAIL_CYCLES = 100;          // exceeds the worst-case latency (sine, 10 terms)
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = 32'd0;   // [31:0] angle
    logic        s_tuser   = 1'b0;    // [0] op
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;             // [31:0] value
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data  = 4'd0;

    sincos_scoreboard sb;
    int               idle_cycles = 0;
    bit               long_hold_done = 1'b0;

    always #2 clk = ~clk;

    taylor_sine_cosine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // beat monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_terms(cfg_data);
            if (s_tvalid && s_tready)
                sb.note_input(trig_op_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("taylor_sine_cosine_tb NOT OK");
                $finish;
            end
        end
    end

    // receiver: stall modes of random length, one long hold early on
    initial
    begin
        int mode;
        int mode_left;
        mode_left = 0;
        mode      = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && sb.results_seen >= 60)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge clk);
        end
    end

    function automatic logic [31:0] pick_angle();
        int k;
        int off;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return 32'($urandom_range(0, 2 * PI_Q)) - 32'(PI_Q);
            7:
            begin
                // near multiples of pi
                k   = int'($urandom_range(0, 4)) - 2;
                off = int'($urandom_range(0, 16)) - 8;
                return 32'(k * PI_Q + off);
            end
            8:          return 32'($urandom_range(0, 2047)) - 32'd1024;
            default:
                return $urandom_range(0, 1) ? (32'h7FFF_FFFF - 32'($urandom_range(0, 15)))
                                            : (32'h8000_0000 + 32'($urandom_range(0, 15)));
        endcase
    endfunction

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_item(trig_op_t op, logic [31:0] angle);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= angle;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_terms(logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.expected_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(int count);
        int sent;
        int burst;
        int gap;
        int j;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            for (j = 0; j < burst && sent < count; j++)
            begin
                send_item(trig_op_t'($urandom_range(0, 1)), pick_angle());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0 && sent < count)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] directed_angles[12];
        logic [3:0]  phase_terms[NUM_PHASES];
        int          i;
        int          p;

        directed_angles = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'(PI_Q), 32'(-PI_Q), 32'(PI_Q - 1), 32'(HALF_PI_Q),
                            32'(-HALF_PI_Q), 32'(TWO_PI_Q), 32'h0001_0000};
        // zero and above-max term counts exercise the clamps
        phase_terms = '{4'd0, 4'd1, 4'd15, 4'd10, 4'd2, 4'd9,
                        4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                        4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))};

        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass at the reset term count
        for (i = 0; i < 12; i++)
        begin
            send_item(OP_SINE, directed_angles[i]);
            send_item(OP_COSINE, directed_angles[i]);
        end
        s_tvalid <= 1'b0;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            write_terms(phase_terms[p]);
            run_phase(PHASE_ITEMS);
        end

        while (sb.expected_values.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.expected_values.size() == 0)
            $display("taylor_sine_cosine_tb OK");
        else
            $display("taylor_sine_cosine_tb NOT OK");
        $finish;
    end
endmodule

`default_nettype wire

/* taylor_sine_cosine.f */
rtl/tsc_pkg.sv
rtl/tsc_seq.sv
rtl/tsc_dp.sv
rtl/taylor_sine_cosine.sv
dv/taylor_sine_cosine_tb.sv
